FILE: src/row_list_cursor_delete_undo_assert.svh
// Assertion macros for the row list cursor block.
`ifndef ROW_LIST_CURSOR_DELETE_UNDO_ASSERT_SVH
`define ROW_LIST_CURSOR_DELETE_UNDO_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RLCDU_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rlcdu assertion failed");

`define RLCDU_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rlcdu assertion failed");

`else

`define RLCDU_ASSERT_IMP(name, ck, rn, ante, cons)

`define RLCDU_ASSERT_NXT(name, ck, rn, ante, cons)

`endif

`endif

FILE: src/rlcdu_pkg.sv
// Shared types, codes and widths of the row list cursor block.
package rlcdu_pkg;

  localparam int MAX_ROWS_DEF = 64;

  localparam int CMD_W      = 3;
  localparam int AMT_W      = 6;
  localparam int CUR_W      = 6;
  localparam int CNT_W      = 7;
  localparam int MASK_W     = 64;
  localparam int STS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int ROWCNT_W   = 7;
  localparam int START_W    = 6;

  localparam logic [CMD_W-1:0] CMD_UP    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CUT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNDO  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd4;

  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_CLAMP   = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STS_W-1:0] ST_REFUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [AMT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [CUR_W-1:0]  cursor_row;
    logic [CNT_W-1:0]  live_count;
    logic [MASK_W-1:0] live_mask;
    logic [STS_W-1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  typedef enum logic [1:0] {
    RD_CURSOR,
    RD_LINK,
    RD_ROW
  } rd_sel_t;

  typedef struct packed {
    logic             load_in;
    rd_sel_t          rd_sel;
    logic             step;
    logic             cut;
    logic             pop;
    logic             relink;
    logic             fill_start;
    logic             fill;
    logic             begin_fin;
    logic             set_status;
    logic [STS_W-1:0] status;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             amount_zero;
    logic             depth_zero;
    logic             nb_valid;
    logic             remain_one;
    logic             cut_ok;
    logic             fill_last;
  } dp_sts_t;

endpackage

FILE: src/rlcdu_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface rlcdu_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

FILE: src/rlcdu_ctrl.sv
// Controller state machine sequencing reads and writes of the list datapath.
module rlcdu_ctrl import rlcdu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output logic    in_ready,
  output logic    out_valid,
  output dp_cmd_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MV_RD,
    S_MV_STEP,
    S_CUT_RD,
    S_CUT_WR,
    S_UN_POP,
    S_UN_RD,
    S_UN_WR,
    S_FILL,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    ctl           = '0;
    ctl.rd_sel    = RD_CURSOR;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_UP, CMD_DOWN: begin
            state_nxt = sts.amount_zero ? S_FINISH : S_MV_RD;
          end
          CMD_CUT: begin
            state_nxt = S_CUT_RD;
          end
          CMD_UNDO: begin
            if (sts.depth_zero) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_EMPTY;
              state_nxt      = S_FINISH;
            end else begin
              state_nxt = S_UN_POP;
            end
          end
          CMD_BEGIN: begin
            ctl.fill_start = 1'b1;
            state_nxt      = S_FILL;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_MV_RD: begin
        state_nxt = S_MV_STEP;
      end
      S_MV_STEP: begin
        if (!sts.nb_valid) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_CLAMP;
          state_nxt      = S_FINISH;
        end else begin
          ctl.step   = 1'b1;
          ctl.rd_sel = RD_LINK;
          if (sts.remain_one) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_CUT_RD: begin
        state_nxt = S_CUT_WR;
      end
      S_CUT_WR: begin
        if (sts.cut_ok) begin
          ctl.cut = 1'b1;
        end else begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_REFUSED;
        end
        state_nxt = S_FINISH;
      end
      S_UN_POP: begin
        ctl.pop   = 1'b1;
        state_nxt = S_UN_RD;
      end
      S_UN_RD: begin
        ctl.rd_sel = RD_ROW;
        state_nxt  = S_UN_WR;
      end
      S_UN_WR: begin
        ctl.relink = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FILL: begin
        ctl.fill = 1'b1;
        if (sts.fill_last) begin
          ctl.begin_fin = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/rlcdu_dpath.sv
// Datapath: link memories, undo stack, cursor, live mask and result register.
module rlcdu_dpath import rlcdu_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             ctl,
  input  in_item_t            in_item,
  input  logic [ROWCNT_W-1:0] row_count,
  input  logic [START_W-1:0]  start_row,
  output dp_sts_t             sts,
  output out_item_t           out_item
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int LW = $clog2(MAX_ROWS + 1);
  localparam logic [LW-1:0] NO_LINK = LW'(MAX_ROWS);

  logic [LW-1:0] prev_mem  [MAX_ROWS];
  logic [LW-1:0] next_mem  [MAX_ROWS];
  logic [RW-1:0] stack_mem [MAX_ROWS];

  logic [LW-1:0] prev_rd_r, next_rd_r;
  logic [RW-1:0] stack_rd_r;

  logic [CMD_W-1:0]    cmd_r;
  logic [AMT_W-1:0]    remain_r;
  logic [STS_W-1:0]    status_r;
  logic [RW-1:0]       fill_r;
  out_item_t           out_item_r;

  logic [RW-1:0]       cursor_r, cursor_nxt;
  logic [MAX_ROWS-1:0] live_r, live_nxt;
  logic [LW-1:0]       cnt_r, cnt_nxt;
  logic [LW-1:0]       depth_r, depth_nxt;

  logic [LW-1:0]       nb;
  logic                nb_valid, p_valid, q_valid;
  logic [ROWCNT_W-1:0] n_full;
  logic [LW-1:0]       n;
  logic [RW-1:0]       start_clamp;
  logic [LW-1:0]       fill_ext, fill_inc;
  logic                fill_last;
  logic [RW-1:0]       rd_addr;
  logic [RW-1:0]       pop_idx;
  logic [LW-1:0]       row_ext;
  logic [MAX_ROWS-1:0] low_mask;

  logic                prev_we, next_we;
  logic [RW-1:0]       prev_wa, next_wa;
  logic [LW-1:0]       prev_wd, next_wd;

  assign nb       = (cmd_r == CMD_UP) ? prev_rd_r : next_rd_r;
  assign nb_valid = nb < NO_LINK;
  assign p_valid  = prev_rd_r < NO_LINK;
  assign q_valid  = next_rd_r < NO_LINK;

  assign n_full = (row_count < ROWCNT_W'(2)) ? ROWCNT_W'(2) :
                  (row_count > ROWCNT_W'(MAX_ROWS)) ? ROWCNT_W'(MAX_ROWS) : row_count;
  assign n      = LW'(n_full);
  assign start_clamp = (ROWCNT_W'(start_row) < n_full) ? RW'(start_row)
                                                       : RW'(n_full - ROWCNT_W'(1));

  assign fill_ext  = LW'(fill_r);
  assign fill_inc  = fill_ext + LW'(1);
  assign fill_last = (fill_inc == n);

  assign pop_idx = RW'(depth_r - LW'(1));
  assign row_ext = LW'(stack_rd_r);

  always_comb begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      low_mask[i] = (LW'(i) < n);
    end
  end

  always_comb begin
    unique case (ctl.rd_sel)
      RD_LINK:   rd_addr = nb[RW-1:0];
      RD_ROW:    rd_addr = stack_rd_r;
      default:   rd_addr = cursor_r;
    endcase
  end

  always_comb begin
    prev_we = 1'b0;
    prev_wa = fill_r;
    prev_wd = NO_LINK;
    next_we = 1'b0;
    next_wa = fill_r;
    next_wd = NO_LINK;
    if (ctl.fill) begin
      prev_we = 1'b1;
      prev_wd = (fill_r == '0) ? NO_LINK : fill_ext - LW'(1);
      next_we = 1'b1;
      next_wd = fill_last ? NO_LINK : fill_inc;
    end else if (ctl.cut) begin
      prev_we = q_valid;
      prev_wa = next_rd_r[RW-1:0];
      prev_wd = prev_rd_r;
      next_we = p_valid;
      next_wa = prev_rd_r[RW-1:0];
      next_wd = next_rd_r;
    end else if (ctl.relink) begin
      prev_we = q_valid;
      prev_wa = next_rd_r[RW-1:0];
      prev_wd = row_ext;
      next_we = p_valid;
      next_wa = prev_rd_r[RW-1:0];
      next_wd = row_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    prev_rd_r <= prev_mem[rd_addr];
    next_rd_r <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.cut) begin
      stack_mem[depth_r[RW-1:0]] <= cursor_r;
    end
    if (ctl.pop) begin
      stack_rd_r <= stack_mem[pop_idx];
    end
  end

  always_comb begin
    cursor_nxt = cursor_r;
    live_nxt   = live_r;
    cnt_nxt    = cnt_r;
    depth_nxt  = depth_r;
    if (ctl.step) begin
      cursor_nxt = nb[RW-1:0];
    end
    if (ctl.cut) begin
      cursor_nxt         = q_valid ? next_rd_r[RW-1:0] : prev_rd_r[RW-1:0];
      live_nxt[cursor_r] = 1'b0;
      cnt_nxt            = cnt_r - LW'(1);
      depth_nxt          = depth_r + LW'(1);
    end
    if (ctl.pop) begin
      depth_nxt = depth_r - LW'(1);
    end
    if (ctl.relink) begin
      live_nxt[stack_rd_r] = 1'b1;
      cnt_nxt              = cnt_r + LW'(1);
    end
    if (ctl.begin_fin) begin
      cursor_nxt = start_clamp;
      live_nxt   = low_mask;
      cnt_nxt    = n;
      depth_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      live_r   <= '1;
      cnt_r    <= LW'(MAX_ROWS);
      depth_r  <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      live_r   <= live_nxt;
      cnt_r    <= cnt_nxt;
      depth_r  <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r    <= in_item.cmd;
      remain_r <= in_item.amount;
      status_r <= ST_OK;
    end
    if (ctl.step) begin
      remain_r <= remain_r - AMT_W'(1);
    end
    if (ctl.set_status) begin
      status_r <= ctl.status;
    end
    if (ctl.fill_start) begin
      fill_r <= '0;
    end else if (ctl.fill) begin
      fill_r <= fill_inc[RW-1:0];
    end
    if (ctl.out_load) begin
      out_item_r.cursor_row <= CUR_W'(cursor_r);
      out_item_r.live_count <= CNT_W'(cnt_r);
      out_item_r.live_mask  <= MASK_W'(live_r);
      out_item_r.status     <= status_r;
    end
  end

  assign out_item = out_item_r;

  assign sts.cmd         = cmd_r;
  assign sts.amount_zero = (remain_r == '0);
  assign sts.depth_zero  = (depth_r == '0);
  assign sts.nb_valid    = nb_valid;
  assign sts.remain_one  = (remain_r == AMT_W'(1));
  assign sts.cut_ok      = (p_valid || q_valid) && (depth_r < LW'(MAX_ROWS));
  assign sts.fill_last   = fill_last;

endmodule

FILE: src/row_list_cursor_delete_undo.sv
// Top level of the row list with cursor, cut and undo.
//
//   channel  dir  payload                                    handshake
//   in_ch    in   cmd, amount                                valid/ready
//   out_ch   out  cursor_row, live_count, live_mask, status  valid/ready
//   cfg_ch   in   index, data (0 row_count, 1 start_row)     valid/ready, always ready
//
// Up/down step one link per cycle until the amount is used up or the list end clamps them;
// undo on an empty stack reports empty, and begin writes the links of the clamped row_count rows.
// Reset clears the cursor and undo depth and marks every row live; the links hold
// nothing usable until the first begin transaction.
// A new transaction is accepted as soon as the previous result sits in the output
// register; a stalled output holds the block in its finish state.
`include "row_list_cursor_delete_undo_assert.svh"

module row_list_cursor_delete_undo import rlcdu_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  rlcdu_chan_if.sink   in_ch,
  rlcdu_chan_if.source out_ch,
  rlcdu_chan_if.sink   cfg_ch
);

  logic [ROWCNT_W-1:0] row_count_r;
  logic [START_W-1:0]  start_row_r;

  dp_cmd_t   ctl;
  dp_sts_t   sts;
  out_item_t out_item;
  logic      in_ready;
  logic      out_valid;
  logic      in_item_ok;
  logic [5:0] dp_ops;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROWCNT_W'(MAX_ROWS_DEF);
      start_row_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.index)
        CFG_ROW_COUNT: row_count_r <= cfg_ch.payload.data;
        CFG_START_ROW: start_row_r <= cfg_ch.payload.data[START_W-1:0];
        default: ;
      endcase
    end
  end

  rlcdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  rlcdu_dpath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_item   (in_ch.payload),
    .row_count (row_count_r),
    .start_row (start_row_r),
    .sts       (sts),
    .out_item  (out_item)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  assign in_item_ok = in_ch.valid && in_ready;
  assign dp_ops     = {ctl.step, ctl.cut, ctl.pop, ctl.relink, ctl.fill, ctl.out_load};

  `RLCDU_ASSERT_IMP(a_one_op, clk, rst_n, 1'b1, $onehot0(dp_ops))
  `RLCDU_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_item_ok, !in_ch.ready)
  `RLCDU_ASSERT_IMP(a_load_slot_free, clk, rst_n, ctl.out_load, !out_valid || out_ch.ready)
  `RLCDU_ASSERT_NXT(a_load_shows, clk, rst_n, ctl.out_load, out_ch.valid)

endmodule
